// ----- sv/levinson_durbin_solver_macros.svh -----
// Assertion macros for the Levinson-Durbin solver.
`ifndef LEVINSON_DURBIN_SOLVER_MACROS_SVH
`define LEVINSON_DURBIN_SOLVER_MACROS_SVH
`ifndef SYNTH
`define LDS_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("lds assertion failed");
`define LDS_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("lds assertion failed");
`else
`define LDS_ASSERT_IMP(lbl, a, b)
`define LDS_ASSERT_NXT(lbl, a, b)
`endif
`endif

// ----- sv/lds_pkg.sv -----
// Shared types, codes and helpers of the Levinson-Durbin solver.
`default_nettype none
package lds_pkg;
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_COEF = 2'd0;
  localparam kind_t KIND_POWER = 2'd1;
  localparam kind_t KIND_FAIL = 2'd2;
  localparam int DIV_STEPS = 63;

  function automatic logic signed [31:0] sat32(input logic signed [66:0] x);
    logic signed [31:0] r;
    if (x > 67'sh7fffffff) r = 32'sh7fffffff;
    else if (x < -67'sh80000000) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [66:0] x);
    logic signed [63:0] r;
    if (x > 67'sh7fffffffffffffff) r = 64'sh7fffffffffffffff;
    else if (x < -67'sh8000000000000000) r = 64'sh8000000000000000;
    else r = x[63:0];
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- sv/lds_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- sv/levinson_durbin_solver.sv -----
// Levinson-Durbin solver: top level with sequencer, shared multiplier and divider.
//
// Usage: write model_order (1..MAX_ORDER; 0 acts as 1, larger values clamp)
// through cfg_we/cfg_data while idle; a write also drops partly loaded lags.
// Requests on the input channel (in_valid/in_stall, lag_value) carry lags
// r[0..p], one per cycle while the block is loading; in_stall is also high
// during reset and while cfg_we is high. The request that brings r[p] starts
// a solve; in_stall stays high until its last result is taken.
// Results leave on out_valid/out_stall: p coefficients (kind 0, negated, Q4.27)
// in index order, then the error power (kind 1) with last_of_run set, or one
// failure result (kind 2) with last_of_run set.
// Solve: fetch r[0], then for each order step i: lag fetch, multiply-accumulate,
// the check and the 63-step one-bit-per-cycle divide, copy, update and error
// power, all on one shared 33x33 multiplier and one coef RAM port.
// Output then sends the coefficients, each read via ST_ORD and ST_OLD, and
// then the error power, waiting out receiver stalls. A stalled result holds
// in the output register.
// Reset: order 4, load count zero, no result pending; RAMs are not cleared.
`default_nettype none
module levinson_durbin_solver #(
  parameter int MAX_ORDER = 16,
  parameter int LAG_WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [4:0]                  cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic signed [LAG_WIDTH-1:0] lag_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       result_kind,
  output logic [3:0]                       coef_index,
  output logic signed [31:0]               result_value,
  output logic                             last_of_run
);
  localparam int LAW = $clog2(MAX_ORDER + 1);
  localparam int CAW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int XW = (LAG_WIDTH > 32) ? LAG_WIDTH : 32;

  typedef enum logic [4:0] {
    ST_LOAD, ST_R0, ST_R0W, ST_ACCI, ST_ACCW, ST_MR, ST_MM, ST_MA, ST_CHK,
    ST_DIV, ST_KQ, ST_CR, ST_CW, ST_NEW, ST_UR1, ST_UR2, ST_UM, ST_UW,
    ST_E1, ST_E2, ST_E3, ST_ORD, ST_OLD, ST_OWAIT
  } state_t;

  state_t state;
  logic [4:0] model_order;
  logic [LAW-1:0] load_count, i, j, p;
  logic signed [31:0] err, kq, copyj;
  logic signed [63:0] acc;
  logic signed [65:0] prod;
  logic [62:0] dq;
  logic [32:0] rem;
  logic [5:0] dcnt;
  logic dneg;

  logic signed [32:0] ma, mb, f;
  logic signed [35:0] f_wide;
  logic signed [XW-1:0] lag_x;
  logic signed [31:0] lag_sat;
  logic signed [31:0] lag_rd, coef_rd, copy_rd;
  logic [31:0] lag_rdata, coef_rdata, copy_rdata, coef_wdata;
  logic [LAW-1:0] lag_raddr;
  logic [CAW-1:0] coef_raddr, coef_waddr, copy_raddr;
  logic coef_we, copy_we, lag_we, in_acc;
  logic [32:0] rem_sh;
  logic signed [63:0] acc_c, acc_mag;

  assign in_stall = rst || cfg_we || (state != ST_LOAD);
  assign in_acc = in_valid && !in_stall;
  assign lag_we = in_acc;

  always_comb begin
    if (model_order == 5'd0) p = LAW'(1);
    else if (6'(model_order) > 6'(MAX_ORDER)) p = LAW'(MAX_ORDER);
    else p = LAW'(model_order);
  end

  assign lag_x = XW'(lag_value);
  always_comb begin
    if (lag_x > XW'(32'sh7fffffff)) lag_sat = 32'sh7fffffff;
    else if (lag_x < XW'(32'sh80000000)) lag_sat = 32'sh80000000;
    else lag_sat = lag_x[31:0];
  end

  assign lag_rd = lag_rdata;
  assign coef_rd = coef_rdata;
  assign copy_rd = copy_rdata;

  always_comb begin
    lag_raddr = '0;
    coef_raddr = j[CAW-1:0];
    copy_raddr = j[CAW-1:0];
    case (state)
      ST_ACCI: lag_raddr = i + LAW'(1);
      ST_MR: lag_raddr = i - j;
      ST_UR2: copy_raddr = CAW'(i - LAW'(1) - j);
      default: lag_raddr = '0;
    endcase
  end

  always_comb begin
    coef_we = (state == ST_NEW) || (state == ST_UW);
    copy_we = (state == ST_CW);
    coef_waddr = (state == ST_NEW) ? i[CAW-1:0] : j[CAW-1:0];
    coef_wdata = (state == ST_NEW) ? 32'(kq >>> 3)
               : lds_pkg::sat32(67'(copyj) - 67'($signed(prod[65:30])));
  end

  assign f_wide = 36'sd1073741824 - $signed(prod[65:30]);
  assign f = f_wide[32:0];

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      ST_MM: begin
        ma = 33'(coef_rd);
        mb = 33'(lag_rd);
      end
      ST_UM: begin
        ma = 33'(kq);
        mb = 33'(copy_rd);
      end
      ST_E1: begin
        ma = 33'(kq);
        mb = 33'(kq);
      end
      ST_E2: begin
        ma = 33'(err);
        mb = f;
      end
      default: ma = '0;
    endcase
  end

  assign rem_sh = {rem[31:0], dq[62]};
  always_comb begin
    if (acc > 64'sh0800000000000000) acc_c = 64'sh0800000000000000;
    else if (acc < -64'sh0800000000000000) acc_c = -64'sh0800000000000000;
    else acc_c = acc;
    acc_mag = acc_c[63] ? -acc_c : acc_c;
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (rst) begin
      state <= ST_LOAD;
      model_order <= 5'd4;
      load_count <= '0;
      err <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        model_order <= cfg_data;
        load_count <= '0;
      end
      case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (load_count == p) begin
              load_count <= '0;
              state <= ST_R0;
            end else begin
              load_count <= load_count + LAW'(1);
            end
          end
        end
        ST_R0: state <= ST_R0W;
        ST_R0W: begin
          err <= lag_rd;
          i <= '0;
          if (lag_rd <= 0) begin
            result_kind <= lds_pkg::KIND_FAIL;
            coef_index <= '0;
            result_value <= '0;
            last_of_run <= 1'b1;
            out_valid <= 1'b1;
            state <= ST_OWAIT;
          end else begin
            state <= ST_ACCI;
          end
        end
        ST_ACCI: state <= ST_ACCW;
        ST_ACCW: begin
          acc <= 64'(lag_rd) <<< 27;
          j <= '0;
          state <= (i == '0) ? ST_CHK : ST_MR;
        end
        ST_MR: state <= ST_MM;
        ST_MM: state <= ST_MA;
        ST_MA: begin
          acc <= lds_pkg::sat64(67'(acc) - 67'(prod));
          j <= j + LAW'(1);
          state <= (j + LAW'(1) == i) ? ST_CHK : ST_MR;
        end
        ST_CHK: begin
          if (err <= 0) begin
            result_kind <= lds_pkg::KIND_FAIL;
            coef_index <= '0;
            result_value <= '0;
            last_of_run <= 1'b1;
            out_valid <= 1'b1;
            state <= ST_OWAIT;
          end else begin
            dq <= {acc_mag[59:0], 3'b000};
            dneg <= acc_c[63];
            rem <= '0;
            dcnt <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (rem_sh >= {1'b0, err}) begin
            rem <= rem_sh - {1'b0, err};
            dq <= {dq[61:0], 1'b1};
          end else begin
            rem <= rem_sh;
            dq <= {dq[61:0], 1'b0};
          end
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'(lds_pkg::DIV_STEPS - 1)) state <= ST_KQ;
        end
        ST_KQ: begin
          if (!dneg) kq <= (dq > 63'h7fffffff) ? 32'sh7fffffff : dq[31:0];
          else kq <= (dq > 63'h80000000) ? 32'sh80000000 : -dq[31:0];
          j <= '0;
          state <= (i == '0) ? ST_NEW : ST_CR;
        end
        ST_CR: state <= ST_CW;
        ST_CW: begin
          j <= j + LAW'(1);
          state <= (j + LAW'(1) == i) ? ST_NEW : ST_CR;
        end
        ST_NEW: begin
          j <= '0;
          state <= (i == '0) ? ST_E1 : ST_UR1;
        end
        ST_UR1: state <= ST_UR2;
        ST_UR2: begin
          copyj <= copy_rd;
          state <= ST_UM;
        end
        ST_UM: state <= ST_UW;
        ST_UW: begin
          j <= j + LAW'(1);
          state <= (j + LAW'(1) == i) ? ST_E1 : ST_UR1;
        end
        ST_E1: state <= ST_E2;
        ST_E2: state <= ST_E3;
        ST_E3: begin
          err <= lds_pkg::sat32(67'($signed(prod[65:30])));
          i <= i + LAW'(1);
          j <= '0;
          state <= (i + LAW'(1) == p) ? ST_ORD : ST_ACCI;
        end
        ST_ORD: state <= ST_OLD;
        ST_OLD: begin
          result_kind <= lds_pkg::KIND_COEF;
          coef_index <= 4'(j);
          result_value <= (coef_rd == 32'sh80000000) ? 32'sh7fffffff : -coef_rd;
          last_of_run <= 1'b0;
          out_valid <= 1'b1;
          state <= ST_OWAIT;
        end
        ST_OWAIT: begin
          if (!out_stall) begin
            if (last_of_run) begin
              out_valid <= 1'b0;
              state <= ST_LOAD;
            end else if (j + LAW'(1) == p) begin
              result_kind <= lds_pkg::KIND_POWER;
              coef_index <= '0;
              result_value <= err;
              last_of_run <= 1'b1;
            end else begin
              out_valid <= 1'b0;
              j <= j + LAW'(1);
              state <= ST_ORD;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  lds_ram #(.WIDTH(32), .DEPTH(MAX_ORDER + 1)) u_lag_ram (
    .clk(clk), .we(lag_we), .waddr(load_count), .wdata(lag_sat),
    .raddr(lag_raddr), .rdata(lag_rdata)
  );

  lds_ram #(.WIDTH(32), .DEPTH(MAX_ORDER)) u_coef_ram (
    .clk(clk), .we(coef_we), .waddr(coef_waddr), .wdata(coef_wdata),
    .raddr(coef_raddr), .rdata(coef_rdata)
  );

  lds_ram #(.WIDTH(32), .DEPTH(MAX_ORDER)) u_copy_ram (
    .clk(clk), .we(copy_we), .waddr(j[CAW-1:0]), .wdata(coef_rdata),
    .raddr(copy_raddr), .rdata(copy_rdata)
  );

`include "levinson_durbin_solver_macros.svh"
  `LDS_ASSERT_IMP(a_busy_when_out, out_valid, in_stall)
  `LDS_ASSERT_NXT(a_last_ends, out_valid && !out_stall && last_of_run, !out_valid)
  `LDS_ASSERT_IMP(a_fail_form, out_valid && (result_kind == lds_pkg::KIND_FAIL), (result_value == 32'sd0) && last_of_run)
endmodule
`default_nettype wire
